// ===== sv/wsbe_pkg.sv =====
// Shared types and constants for the WS2812 three-bit line encoder.
// Used by the lane, the merge stage and the top level; depends on nothing.
`timescale 1ns / 1ps

package wsbe_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_W  = 24;
   localparam int unsigned CHAN_W  = 2;
   localparam int unsigned NUM_CHAN = 3;

   // Every line bit group starts as 100; the middle bit carries the data.
   localparam logic [WORD_W-1:0] LINE_FRAME = 24'h924924;

   localparam logic [BYTE_W-1:0] BRIGHTNESS_RESET = 8'hFF;

   localparam logic [CHAN_W-1:0] CHAN_RED   = 2'd0;
   localparam logic [CHAN_W-1:0] CHAN_GREEN = 2'd1;
   localparam logic [CHAN_W-1:0] CHAN_BLUE  = 2'd2;

   typedef logic [WORD_W-1:0] code_word_type;
   typedef code_word_type [NUM_CHAN-1:0] word_set_type;

endpackage

// ===== sv/wsbe_lane.sv =====
// One colour lane: brightness scaling and expansion to 24 line bits.
// Depends on wsbe_pkg.
`timescale 1ns / 1ps

module wsbe_lane (
   input  logic [wsbe_pkg::BYTE_W-1:0] color_byte,
   input  logic [wsbe_pkg::BYTE_W-1:0] brightness,
   output wsbe_pkg::code_word_type     code_word
);

   logic [wsbe_pkg::BYTE_W:0]     factor;
   logic [2*wsbe_pkg::BYTE_W-1:0] product;
   logic [wsbe_pkg::BYTE_W-1:0]   scaled;

   // The product never exceeds 255 * 256, so the scaled byte is bits 15:8.
   assign factor  = {1'b0, brightness} + {{wsbe_pkg::BYTE_W{1'b0}}, 1'b1};
   assign product = {{wsbe_pkg::BYTE_W{1'b0}}, color_byte}
                  * {{(wsbe_pkg::BYTE_W-1){1'b0}}, factor};
   assign scaled  = product[2*wsbe_pkg::BYTE_W-1:wsbe_pkg::BYTE_W];

   always_comb begin
      code_word = wsbe_pkg::LINE_FRAME;
      for (int i = 0; i < wsbe_pkg::BYTE_W; i++) begin
         code_word[3*i+1] = scaled[i];
      end
   end

endmodule

// ===== sv/wsbe_merge.sv =====
// Merge stage: holds the three lane results of one pixel and sends them
// one word a cycle, unless the output stalls, through an output register. Depends on wsbe_pkg.
`timescale 1ns / 1ps

module wsbe_merge (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_stall,
   input  wsbe_pkg::word_set_type      in_words,
   output logic                        out_valid,
   input  logic                        out_stall,
   output wsbe_pkg::code_word_type     out_word,
   output logic [wsbe_pkg::CHAN_W-1:0] out_channel,
   output logic                        out_last
);

   wsbe_pkg::word_set_type        words_ff, words_in;
   logic                          pend_ff, pend_in;
   logic [wsbe_pkg::CHAN_W-1:0]   chan_ff, chan_in;
   logic                          valid_ff, valid_in;
   wsbe_pkg::code_word_type       word_ff, word_in;
   logic [wsbe_pkg::CHAN_W-1:0]   ochan_ff, ochan_in;
   logic                          last_ff, last_in;
   logic                          pop;
   logic                          accept;

   // A pending word moves out whenever the output register is empty or being taken.
   assign pop      = pend_ff && (!valid_ff || !out_stall);
   // A new pixel may enter as the blue word of the current one leaves.
   assign in_stall = pend_ff && !(pop && (chan_ff == wsbe_pkg::CHAN_BLUE));
   assign accept   = in_valid && !in_stall;

   always_comb begin
      words_in = words_ff;
      pend_in  = pend_ff;
      chan_in  = chan_ff;
      valid_in = valid_ff;
      word_in  = word_ff;
      ochan_in = ochan_ff;
      last_in  = last_ff;
      if (pop) begin
         valid_in = 1'b1;
         word_in  = words_ff[chan_ff];
         ochan_in = chan_ff;
         last_in  = (chan_ff == wsbe_pkg::CHAN_BLUE);
         if (chan_ff == wsbe_pkg::CHAN_BLUE) begin
            pend_in = 1'b0;
         end else begin
            chan_in = chan_ff + 2'd1;
         end
      end else if (!out_stall) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         words_in = in_words;
         pend_in  = 1'b1;
         chan_in  = wsbe_pkg::CHAN_RED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         chan_ff  <= wsbe_pkg::CHAN_RED;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         chan_ff  <= chan_in;
         valid_ff <= valid_in;
      end
      words_ff <= words_in;
      word_ff  <= word_in;
      ochan_ff <= ochan_in;
      last_ff  <= last_in;
   end

   assign out_valid   = valid_ff;
   assign out_word    = word_ff;
   assign out_channel = ochan_ff;
   assign out_last    = last_ff;

`ifndef SYNTHESIS
   a_accept_starts_red: assert property (@(posedge clock) disable iff (reset)
      accept |=> (pend_ff && (chan_ff == wsbe_pkg::CHAN_RED)))
      else $error("accepted pixel did not restart at the red word");

   a_last_is_blue: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && last_ff) |-> (ochan_ff == wsbe_pkg::CHAN_BLUE))
      else $error("last mark on a word that is not blue");

   a_red_leaves_pending: assert property (@(posedge clock) disable iff (reset)
      (pop && (chan_ff == wsbe_pkg::CHAN_RED)) |=>
         (pend_ff && (chan_ff == wsbe_pkg::CHAN_GREEN)))
      else $error("green word lost after red word");

   a_chan_in_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (chan_ff != 2'd3))
      else $error("pending channel out of range");
`endif

endmodule

// ===== sv/ws2812_spi_bit_expander.sv =====
// Top level of the WS2812 three-bit line encoder with brightness scaling.
// Depends on wsbe_pkg, wsbe_lane and wsbe_merge.
`timescale 1ns / 1ps

// Each pixel word (red, green and blue bytes) is scaled by the brightness
// register as (byte * (brightness + 1)) >> 8 and every bit of the result,
// most significant first, is expanded to three line bits: 100 for a zero and
// 110 for a one. Three code words leave per pixel, red then green then blue,
// and the blue word carries the last mark. The three colours are handled by
// three identical lanes working side by side, one narrow multiply each, and
// a merge stage sends their results one word per cycle, unless the output
// stalls, through an output register. The next pixel is taken in the same
// cycle that the blue word of the current one moves to the output register.
// An accepted pixel is held in the merge stage, and its words then pass
// through the output register. The brightness register resets to 255
// (bytes pass unchanged) and should be written only while no pixel is in
// flight.

module ws2812_spi_bit_expander (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [wsbe_pkg::BYTE_W-1:0] csr_write_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [wsbe_pkg::BYTE_W-1:0] req_red,
   input  logic [wsbe_pkg::BYTE_W-1:0] req_green,
   input  logic [wsbe_pkg::BYTE_W-1:0] req_blue,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [wsbe_pkg::WORD_W-1:0] rsp_code_word,
   output logic [wsbe_pkg::CHAN_W-1:0] rsp_channel,
   output logic                        rsp_last
);

   logic [wsbe_pkg::BYTE_W-1:0] brightness_ff, brightness_in;
   wsbe_pkg::word_set_type      lane_words;

   // Brightness register; written directly, no read-back.
   assign brightness_in = csr_write_enable ? csr_write_data : brightness_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= wsbe_pkg::BRIGHTNESS_RESET;
      end else begin
         brightness_ff <= brightness_in;
      end
   end

   // The three lanes encode the colours of the offered pixel word at once.
   wsbe_lane u_lane_red (
      .color_byte (req_red),
      .brightness (brightness_ff),
      .code_word  (lane_words[wsbe_pkg::CHAN_RED])
   );

   wsbe_lane u_lane_green (
      .color_byte (req_green),
      .brightness (brightness_ff),
      .code_word  (lane_words[wsbe_pkg::CHAN_GREEN])
   );

   wsbe_lane u_lane_blue (
      .color_byte (req_blue),
      .brightness (brightness_ff),
      .code_word  (lane_words[wsbe_pkg::CHAN_BLUE])
   );

   // The merge stage captures the lane results and serialises them.
   wsbe_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_stall    (req_stall),
      .in_words    (lane_words),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_word    (rsp_code_word),
      .out_channel (rsp_channel),
      .out_last    (rsp_last)
   );

endmodule
